### rtl/rgb_3x3_max_filter_top_defines.svh
// ----------------------------------------------------------------------------
// RGB 3x3 max filter assertion macros
// Shared macros for the concurrent checks on the filter's ports.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_MAX_FILTER_TOP_DEFINES_SVH
`define RGB_3X3_MAX_FILTER_TOP_DEFINES_SVH

// Checks a condition at every clock edge, reset included.
`define RGBMF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) (cond)) else $error(msg);

// Checks a same-cycle implication outside of reset.
`define RGBMF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks an implication in the next cycle, outside of reset.
`define RGBMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rgbmf_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 max filter package
// Pixel and window column types, register indexes and the channel max helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbmf_pkg;

   // One RGB pixel; red sits in the lowest byte to match the stream layout.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_pixel_type;

   // One column of the 3x3 window, top row first.
   typedef struct packed {
      rgb_pixel_type top;
      rgb_pixel_type mid;
      rgb_pixel_type bot;
   } rgb_column_type;

   // Window size and register map.
   localparam int WIN_SIZE    = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [12:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   // Per-channel maximum of two pixels.
   function automatic rgb_pixel_type pix_max(input rgb_pixel_type a, input rgb_pixel_type b);
      rgb_pixel_type m;
      m.red   = (a.red   > b.red)   ? a.red   : b.red;
      m.green = (a.green > b.green) ? a.green : b.green;
      m.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
      return m;
   endfunction

endpackage

`default_nettype wire

### rtl/rgb_3x3_max_filter_top.sv
// ----------------------------------------------------------------------------
// RGB 3x3 max filter
// Per-channel 3x3 maximum (dilation) over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Width  Contents
//   req_*    in   24     red, green, blue of the next pixel
//   rsp_*    out  56     max red, green, blue, center column, center row
//                        (tlast marks the last interior result of a frame)
//   csr_*    in   16     image_width (index 0), image_height (index 1)
//
// One pixel beat is accepted per clock while req_tready is high. A result
// follows the pixel that completes its window through the line store read,
// window shift and output register. The line store port (one read, one write
// a cycle) sets the rate. Reset clears counters, valids and size registers
// only; line stores need no clearing pass. A stalled result holds the output
// register while bubbles and border pixels behind it keep moving, so the
// input stalls only when every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module rgb_3x3_max_filter_top import rgbmf_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Pixel input: red [7:0], green [15:8], blue [23:16].
   input  wire logic [23:0]            req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // Result: red [7:0], green [15:8], blue [23:16], center_column [35:24],
   // center_row [51:36], zero padding [55:52].
   output logic [55:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // Register writes.
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ColW = $clog2(MAX_WIDTH);

   // Configuration registers.
   logic [12:0] width_ff;
   logic [15:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
         endcase
      end
   end

   // Last column and last row of the frame after clamping.
   logic [16:0]     width_ext;
   logic [ColW-1:0] last_col;
   logic [15:0]     last_row;

   assign width_ext = {4'd0, width_ff};

   always_comb begin
      priority if (width_ff < 13'd3) begin
         last_col = ColW'(2);
      end else if (width_ext > 17'(MAX_WIDTH)) begin
         last_col = ColW'(MAX_WIDTH - 1);
      end else begin
         last_col = ColW'(width_ext - 17'd1);
      end
      last_row = (height_ff < 16'd3) ? 16'd2 : height_ff - 16'd1;
   end

   // Handshake chain: output register, window stage, read stage.
   logic a_valid_ff, a_emit_ff, a_last_ff;
   logic b_valid_ff, b_emit_ff, b_last_ff;
   logic rsp_valid_ff;
   logic o_ready, b_ready, a_ready;
   logic req_fire, a_move, b_move;

   assign o_ready  = !rsp_valid_ff || rsp_tready;
   assign b_ready  = !b_valid_ff || !b_emit_ff || o_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign req_fire = req_tvalid && a_ready;
   assign a_move   = a_valid_ff && b_ready;
   assign b_move   = b_valid_ff && b_emit_ff && o_ready;

   assign req_tready = a_ready;

   // Raster position of the incoming pixel.
   logic [ColW-1:0] col_ff;
   logic [15:0]     row_ff;
   logic            col_end, row_end;

   assign col_end = col_ff >= last_col;
   assign row_end = row_ff >= last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + ColW'(1);
         end
      end
   end

   // Read stage: pixel and position wait for the line store data.
   rgb_pixel_type   a_pix_ff;
   logic [ColW-1:0] a_col_ff;
   logic [15:0]     a_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_pix_ff  <= rgb_pixel_type'(req_tdata);
         a_col_ff  <= col_ff;
         a_row_ff  <= row_ff;
         a_emit_ff <= (col_ff >= ColW'(2)) && (row_ff >= 16'd2);
         a_last_ff <= col_end && row_end;
      end
   end

   // Line stores: read at accept, rotate the column as it enters the window.
   rgb_pixel_type rd_up, rd_mid;

   rgbmf_linebuf #(
      .DEPTH (MAX_WIDTH),
      .AW    (ColW)
   ) u_linebuf (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_up   (rd_up),
      .rd_mid  (rd_mid),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_up   (rd_mid),
      .wr_mid  (a_pix_ff)
   );

   // Window: a row of column cells, newest column enters cell 0.
   rgb_column_type col_chain [WIN_SIZE];
   rgb_pixel_type  max_chain [WIN_SIZE+1];
   rgb_column_type new_col;

   assign new_col.top = rd_up;
   assign new_col.mid = rd_mid;
   assign new_col.bot = a_pix_ff;
   assign max_chain[0] = '0;

   for (genvar i = 0; i < WIN_SIZE; i++) begin : g_cell
      rgb_column_type cell_in;

      if (i == 0) begin : g_first
         assign cell_in = new_col;
      end else begin : g_next
         assign cell_in = col_chain[i-1];
      end

      rgbmf_cell u_cell (
         .clock   (clock),
         .shift   (a_move),
         .col_in  (cell_in),
         .col_out (col_chain[i]),
         .max_in  (max_chain[i]),
         .max_out (max_chain[i+1])
      );
   end

   // Window stage: position and flags of the pixel now in the window.
   logic [ColW-1:0] b_col_ff;
   logic [15:0]     b_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_col_ff  <= a_col_ff;
         b_row_ff  <= a_row_ff;
         b_emit_ff <= a_emit_ff;
         b_last_ff <= a_last_ff;
      end
   end

   // Output register: only interior pixels produce a beat.
   rgb_pixel_type rsp_max_ff;
   logic [11:0]   rsp_col_ff;
   logic [15:0]   rsp_row_ff;
   logic          rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_ready) begin
         rsp_valid_ff <= b_valid_ff && b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         rsp_max_ff  <= max_chain[WIN_SIZE];
         rsp_col_ff  <= 12'(b_col_ff - ColW'(1));
         rsp_row_ff  <= b_row_ff - 16'd1;
         rsp_last_ff <= b_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, rsp_row_ff, rsp_col_ff, rsp_max_ff};

endmodule

`default_nettype wire

### rtl/rgbmf_linebuf.sv
// ----------------------------------------------------------------------------
// RGB 3x3 max filter line stores
// Upper and middle row memories, one registered read and one write per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbmf_linebuf import rgbmf_pkg::*; #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output rgb_pixel_type      rd_up,
   output rgb_pixel_type      rd_mid,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire rgb_pixel_type wr_up,
   input  wire rgb_pixel_type wr_mid
);

   rgb_pixel_type upper_mem [DEPTH];
   rgb_pixel_type middle_mem [DEPTH];
   rgb_pixel_type rd_up_ff;
   rgb_pixel_type rd_mid_ff;

   // Upper row store: the row two above the incoming pixel.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_up_ff <= upper_mem[rd_addr];
      end
      if (wr_en) begin
         upper_mem[wr_addr] <= wr_up;
      end
   end

   // Middle row store: the row just above the incoming pixel.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mid_ff <= middle_mem[rd_addr];
      end
      if (wr_en) begin
         middle_mem[wr_addr] <= wr_mid;
      end
   end

   assign rd_up  = rd_up_ff;
   assign rd_mid = rd_mid_ff;

endmodule

`default_nettype wire

### rtl/rgbmf_cell.sv
// ----------------------------------------------------------------------------
// RGB 3x3 max filter window cell
// Holds one window column, passes it on at each shift and extends the
// running per-channel maximum handed in by its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbmf_cell import rgbmf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           shift,
   input  wire rgb_column_type col_in,
   output rgb_column_type      col_out,
   input  wire rgb_pixel_type  max_in,
   output rgb_pixel_type       max_out
);

   rgb_column_type col_ff;
   rgb_column_type col_in_q;

   // Column register, loaded from the neighbor on every shift.
   always_comb begin
      col_in_q = shift ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in_q;
   end

   // Running maximum over this column and all cells before it.
   assign max_out = pix_max(max_in, pix_max(col_ff.top, pix_max(col_ff.mid, col_ff.bot)));
   assign col_out = col_ff;

endmodule

`default_nettype wire

### rtl/rgbmf_checker.sv
// ----------------------------------------------------------------------------
// RGB 3x3 max filter port checker
// Watches the filter's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_3x3_max_filter_top_defines.svh"

module rgbmf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   // A stalled result beat stays offered.
   `RGBMF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped while stalled")

   // A stalled result beat keeps its payload.
   `RGBMF_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed while stalled")

   // Results are never on the top border row, and the padding stays zero.
   `RGBMF_ASSERT_IMPLY(a_rsp_interior, rsp_tvalid, (rsp_tdata[51:36] != 16'd0) && (rsp_tdata[55:52] == 4'd0), "rsp center row or padding invalid")

   // No result beat is offered in the cycle after a reset.
   `RGBMF_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind rgb_3x3_max_filter_top rgbmf_checker u_rgbmf_checker (.*);

`default_nettype wire
